FILE: rtl/pcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared constants for the particle collision resolver: op and result codes,
// register indexes and the layout of one particle word.
// ----------------------------------------------------------------------------
package pcr_pkg;

  // request ops
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_ACK    = 2'd3;

  // configuration register indexes
  localparam logic CFG_USE_MASS = 1'b0;
  localparam logic CFG_ACTIVE   = 1'b1;

  // particle word: {x, y, radius, mass}
  localparam int unsigned POS_W  = 32;
  localparam int unsigned RAD_W  = 31;
  localparam int unsigned WORD_W = 2 * POS_W + 2 * RAD_W;

  // one half in Q16.16 and the equal share in Q1.16
  localparam logic [32:0] HALF_Q16  = 33'h0_0000_8000;
  localparam logic [16:0] SHARE_EQ  = 17'h0_8000;

endpackage

FILE: rtl/pcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/particle_collision_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_collision_resolver
// Particle pool with write, read and resolve requests. A resolve walks the
// pool, tests each pair for circle overlap and pushes colliding pairs apart,
// using one shared multiplier, a bit-serial square root and a shift-subtract
// divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | in        | in_valid_i/stall_o | op, self/start index, pos, radius, mass
//  out     | out       | out_valid_o/stall_i| kind, other_index, overlap, x, y, last
//  cfg     | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
//  A write goes from acceptance through S_EMIT to the output register; a read
//  first takes the registered pool word in S_RD_WAIT. A resolve skips the self
//  entry, tests each other entry with squares from the shared multiplier and,
//  for a colliding pair, runs a 32-step square root, two divisions for equal
//  shares or four for mass shares, and multiplies for the shares and moves.
//  in_stall_o is high from acceptance until the last result is registered.
//  A stalled result holds; no new result is loaded until it is taken.
//  Reset clears the control and configuration registers; pool contents are
//  undefined until written.
// ----------------------------------------------------------------------------
module particle_collision_resolver
  import pcr_pkg::*;
#(
  parameter int unsigned PARTICLES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_op_i,
  input  logic [5:0]  in_self_index_i,
  input  logic [5:0]  in_start_index_i,
  input  logic [31:0] in_pos_x_i,
  input  logic [31:0] in_pos_y_i,
  input  logic [30:0] in_radius_i,
  input  logic [30:0] in_mass_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [5:0]  out_other_index_o,
  output logic [31:0] out_overlap_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic        out_last_o
);

  localparam int unsigned AW   = $clog2(PARTICLES);
  localparam logic [6:0]  PCNT = 7'(PARTICLES);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_SELF, S_LOOP, S_OTH, S_ABS, S_MUL, S_MULW,
    S_CMP, S_SQRT, S_OVL, S_DIVL, S_DIV, S_DIVW, S_UPD, S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    MJ_AX2, MJ_AY2, MJ_R2, MJ_S1, MJ_S2, MJ_M1X, MJ_M1Y, MJ_M2X, MJ_M2Y
  } mjob_e;

  typedef enum logic [1:0] {
    DJ_R1, DJ_R2, DJ_UX, DJ_UY
  } djob_e;

  state_e state_q;
  mjob_e  mjob_q;
  djob_e  djob_q;

  logic        use_mass_q;
  logic [6:0]  active_q;
  logic [5:0]  self_q;
  logic [6:0]  i_q;
  logic [1:0]  em_kind_q;
  logic [5:0]  cnt_q;

  // self and other particle
  logic [31:0] sx_q, sy_q, ox_q, oy_q;
  logic [30:0] sr_q, sm_q, or_q, om_q;
  logic        xneg_q, yneg_q;
  logic [31:0] ax_q, ay_q, rsum_q;
  logic [63:0] sxx_q, syy_q, prod_q;
  logic [31:0] dist_q, ov_q;
  logic [16:0] r1_q, r2_q, ux_q, uy_q;
  logic [31:0] s1_q, s2_q, m1x_q, m1y_q, m2x_q, m2y_q;

  // square root and divider state
  logic [63:0] rad_q;
  logic [34:0] srem_q;
  logic [47:0] num_q;
  logic [32:0] drem_q;
  logic [31:0] den_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [5:0]  out_idx_q;
  logic [31:0] out_ov_q, out_x_q, out_y_q;
  logic        out_last_q;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  pcr_ram #(.WIDTH(WORD_W), .DEPTH(PARTICLES)) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [31:0] sat32(input logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end
    return v[33] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  logic        in_acc, self_ok, in_self_ok;
  logic [6:0]  end_w;
  logic [31:0] mul_a, mul_b;
  logic [34:0] sq_sh, sq_trial;
  logic [32:0] dv_sh;
  logic [32:0] ovl_w;
  logic [31:0] mt_w;
  logic [32:0] dx_w, dy_w;
  logic [64:0] dsum_w;

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_self_ok = {1'b0, in_self_index_i} < PCNT;
  assign self_ok    = {1'b0, self_q} < PCNT;
  assign end_w      = (active_q > PCNT) ? PCNT : active_q;
  assign mt_w       = {1'b0, sm_q} + {1'b0, om_q};
  assign dx_w       = {ox_q[31], ox_q} - {sx_q[31], sx_q};
  assign dy_w       = {oy_q[31], oy_q} - {sy_q[31], sy_q};
  assign dsum_w     = {1'b0, sxx_q} + {1'b0, syy_q};
  assign ovl_w      = {1'b0, rsum_q} - {1'b0, dist_q} + HALF_Q16;

  // one root digit and one quotient bit per step
  assign sq_sh    = {srem_q[32:0], rad_q[63:62]};
  assign sq_trial = {1'b0, dist_q, 2'b01};
  assign dv_sh    = {drem_q[31:0], num_q[47]};

  // shared multiplier operands
  always_comb begin
    case (mjob_q)
      MJ_AX2:  begin mul_a = ax_q;           mul_b = ax_q;           end
      MJ_AY2:  begin mul_a = ay_q;           mul_b = ay_q;           end
      MJ_R2:   begin mul_a = rsum_q;         mul_b = rsum_q;         end
      MJ_S1:   begin mul_a = ov_q;           mul_b = {15'd0, r1_q};  end
      MJ_S2:   begin mul_a = ov_q;           mul_b = {15'd0, r2_q};  end
      MJ_M1X:  begin mul_a = s1_q;           mul_b = {15'd0, ux_q};  end
      MJ_M1Y:  begin mul_a = s1_q;           mul_b = {15'd0, uy_q};  end
      MJ_M2X:  begin mul_a = s2_q;           mul_b = {15'd0, ux_q};  end
      default: begin mul_a = s2_q;           mul_b = {15'd0, uy_q};  end
    endcase
  end

  // pool port: self at request time, walk index otherwise
  always_comb begin
    ram_raddr = (state_q == S_IDLE) ? in_self_index_i[AW-1:0] : i_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = i_q[AW-1:0];
    ram_wdata = {sat32({{2{ox_q[31]}}, ox_q} + (xneg_q ? -{2'b0, m2x_q} : {2'b0, m2x_q})),
                 sat32({{2{oy_q[31]}}, oy_q} + (yneg_q ? -{2'b0, m2y_q} : {2'b0, m2y_q})),
                 or_q, om_q};
    if (in_acc && in_op_i == OP_WRITE && in_self_ok) begin
      ram_we    = 1'b1;
      ram_waddr = in_self_index_i[AW-1:0];
      ram_wdata = {in_pos_x_i, in_pos_y_i, in_radius_i, in_mass_i};
    end else if (state_q == S_UPD) begin
      ram_we = 1'b1;
    end else if (state_q == S_LOOP && i_q >= end_w) begin
      ram_we    = 1'b1;
      ram_waddr = self_q[AW-1:0];
      ram_wdata = {sx_q, sy_q, sr_q, sm_q};
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_mass_q <= 1'b0;
      active_q   <= 7'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USE_MASS: use_mass_q <= cfg_data_i[0];
        default:      active_q   <= cfg_data_i;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mjob_q      <= MJ_AX2;
      djob_q      <= DJ_R1;
      out_valid_q <= 1'b0;
      i_q         <= 7'd0;
      self_q      <= 6'd0;
      em_kind_q   <= KIND_ACK;
      cnt_q       <= 6'd0;
    end else begin
      prod_q <= mul_a * mul_b;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            self_q <= in_self_index_i;
            i_q    <= {1'b0, in_start_index_i};
            case (in_op_i)
              OP_WRITE: begin
                em_kind_q <= KIND_ACK;
                state_q   <= S_EMIT;
              end
              OP_READ: begin
                em_kind_q <= KIND_READ;
                state_q   <= S_RD_WAIT;
              end
              OP_RESOLVE: begin
                em_kind_q <= KIND_DONE;
                state_q   <= in_self_ok ? S_SELF : S_EMIT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_RD_WAIT: begin
          ox_q    <= self_ok ? ram_rdata[WORD_W-1 -: 32] : 32'd0;
          oy_q    <= self_ok ? ram_rdata[WORD_W-33 -: 32] : 32'd0;
          state_q <= S_EMIT;
        end
        S_SELF: begin
          {sx_q, sy_q, sr_q, sm_q} <= ram_rdata;
          state_q <= S_LOOP;
        end
        S_LOOP: begin
          if (i_q >= end_w) begin
            em_kind_q <= KIND_DONE;
            state_q   <= S_EMIT;
          end else if (i_q == {1'b0, self_q}) begin
            i_q <= i_q + 7'd1;
          end else begin
            state_q <= S_OTH;
          end
        end
        S_OTH: begin
          {ox_q, oy_q, or_q, om_q} <= ram_rdata;
          state_q <= S_ABS;
        end
        S_ABS: begin
          xneg_q  <= dx_w[32];
          yneg_q  <= dy_w[32];
          ax_q    <= dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
          ay_q    <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
          rsum_q  <= {1'b0, sr_q} + {1'b0, or_q};
          mjob_q  <= MJ_AX2;
          state_q <= S_MUL;
        end
        S_MUL: state_q <= S_MULW;
        S_MULW: begin
          case (mjob_q)
            MJ_AX2: begin sxx_q <= prod_q; mjob_q <= MJ_AY2; state_q <= S_MUL; end
            MJ_AY2: begin syy_q <= prod_q; mjob_q <= MJ_R2; state_q <= S_MUL; end
            MJ_R2:  state_q <= S_CMP;
            MJ_S1:  begin s1_q <= prod_q[47:16]; mjob_q <= MJ_S2; state_q <= S_MUL; end
            MJ_S2:  begin s2_q <= prod_q[47:16]; mjob_q <= MJ_M1X; state_q <= S_MUL; end
            MJ_M1X: begin m1x_q <= prod_q[47:16]; mjob_q <= MJ_M1Y; state_q <= S_MUL; end
            MJ_M1Y: begin m1y_q <= prod_q[47:16]; mjob_q <= MJ_M2X; state_q <= S_MUL; end
            MJ_M2X: begin m2x_q <= prod_q[47:16]; mjob_q <= MJ_M2Y; state_q <= S_MUL; end
            default: begin m2y_q <= prod_q[47:16]; state_q <= S_UPD; end
          endcase
        end
        S_CMP: begin
          // prod_q holds the squared radius sum
          if (dsum_w > {1'b0, prod_q}) begin
            i_q     <= i_q + 7'd1;
            state_q <= S_LOOP;
          end else begin
            rad_q   <= dsum_w[63:0];
            srem_q  <= 35'd0;
            dist_q  <= 32'd0;
            cnt_q   <= 6'd31;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad_q <= {rad_q[61:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            srem_q <= sq_sh - sq_trial;
            dist_q <= {dist_q[30:0], 1'b1};
          end else begin
            srem_q <= sq_sh;
            dist_q <= {dist_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_q <= S_OVL;
          end
        end
        S_OVL: begin
          ov_q      <= ovl_w[32] ? 32'hffff_ffff : ovl_w[31:0];
          em_kind_q <= KIND_REPORT;
          if (dist_q == 32'd0) begin
            state_q <= S_EMIT;
          end else if (use_mass_q && mt_w != 32'd0) begin
            djob_q  <= DJ_R1;
            state_q <= S_DIVL;
          end else begin
            r1_q    <= SHARE_EQ;
            r2_q    <= SHARE_EQ;
            djob_q  <= DJ_UX;
            state_q <= S_DIVL;
          end
        end
        S_DIVL: begin
          case (djob_q)
            DJ_R1:   begin num_q <= {1'b0, om_q, 16'd0}; den_q <= mt_w; end
            DJ_R2:   begin num_q <= {1'b0, sm_q, 16'd0}; den_q <= mt_w; end
            DJ_UX:   begin num_q <= {ax_q, 16'd0}; den_q <= dist_q; end
            default: begin num_q <= {ay_q, 16'd0}; den_q <= dist_q; end
          endcase
          drem_q  <= 33'd0;
          cnt_q   <= 6'd47;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dv_sh >= {1'b0, den_q}) begin
            drem_q <= dv_sh - {1'b0, den_q};
            num_q  <= {num_q[46:0], 1'b1};
          end else begin
            drem_q <= dv_sh;
            num_q  <= {num_q[46:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          case (djob_q)
            DJ_R1:   begin r1_q <= num_q[16:0]; djob_q <= DJ_R2; state_q <= S_DIVL; end
            DJ_R2:   begin r2_q <= num_q[16:0]; djob_q <= DJ_UX; state_q <= S_DIVL; end
            DJ_UX:   begin ux_q <= num_q[16:0]; djob_q <= DJ_UY; state_q <= S_DIVL; end
            default: begin
              uy_q    <= num_q[16:0];
              mjob_q  <= MJ_S1;
              state_q <= S_MUL;
            end
          endcase
        end
        S_UPD: begin
          // other entry is written by the pool port this cycle
          sx_q <= sat32({{2{sx_q[31]}}, sx_q} + (xneg_q ? {2'b0, m1x_q} : -{2'b0, m1x_q}));
          sy_q <= sat32({{2{sy_q[31]}}, sy_q} + (yneg_q ? {2'b0, m1y_q} : -{2'b0, m1y_q}));
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= em_kind_q;
            out_idx_q   <= (em_kind_q == KIND_REPORT) ? i_q[5:0] : 6'd0;
            out_ov_q    <= (em_kind_q == KIND_REPORT) ? ov_q : 32'd0;
            out_x_q     <= (em_kind_q == KIND_READ) ? ox_q : 32'd0;
            out_y_q     <= (em_kind_q == KIND_READ) ? oy_q : 32'd0;
            out_last_q  <= (em_kind_q != KIND_REPORT);
            if (em_kind_q == KIND_REPORT) begin
              i_q     <= i_q + 7'd1;
              state_q <= S_LOOP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_other_index_o = out_idx_q;
  assign out_overlap_o     = out_ov_q;
  assign out_x_o           = out_x_q;
  assign out_y_o           = out_y_q;
  assign out_last_o        = out_last_q;

  // hold a stalled result
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  // busy after any request that produces results
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_op_i != OP_NONE |=> in_stall_o)
    else $error("request not held busy");

  // reports never close a request
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_REPORT |-> !out_last_o)
    else $error("report marked last");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for particle_collision_resolver. A directed table of
// writes, reads and resolves with configuration changes runs first, then
// random phases over a filled pool. Every result is compared field by field
// with a behavioral copy of the pool that resolves collisions in Q16.16.
// ----------------------------------------------------------------------------
module testbench
  import pcr_pkg::*;
();

  localparam int unsigned POOL      = 64;
  localparam int unsigned SETTLE    = 40;
  localparam longint      CYCLE_MAX = 20000000;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  other;
    logic [31:0] overlap;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [6:0]  cfg_val;
    logic [1:0]  op;
    logic [5:0]  self_idx;
    logic [5:0]  start_idx;
    logic [31:0] px;
    logic [31:0] py;
    logic [30:0] rad;
    logic [30:0] mass;
    bit          lit;
    logic [31:0] lx;
    logic [31:0] ly;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_op_i = '0;
  logic [5:0]  in_self_index_i = '0;
  logic [5:0]  in_start_index_i = '0;
  logic [31:0] in_pos_x_i = '0;
  logic [31:0] in_pos_y_i = '0;
  logic [30:0] in_radius_i = '0;
  logic [30:0] in_mass_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [5:0]  out_other_index_o;
  logic [31:0] out_overlap_o;
  logic [31:0] out_x_o;
  logic [31:0] out_y_o;
  logic        out_last_o;

  particle_collision_resolver #(.PARTICLES(POOL)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow pool and registers
  longint          pool_x [POOL];
  longint          pool_y [POOL];
  longint unsigned pool_rad [POOL];
  longint unsigned pool_mass [POOL];
  bit              mass_split;
  int unsigned     active_n;

  result_t expected_q[$];
  int      fails;
  int      n_requests;
  int      n_reports;
  longint  cycles;

  // stall pattern of the result side
  int unsigned stall_mode;
  int unsigned stall_pct;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles[7:0] == 8'd0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_pct  <= $urandom_range(10, 80);
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      default: out_stall_i <= (cycles % 7) < 3;
    endcase
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    stall_mode = 0;
    stall_pct = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // trunc(s * trunc(|d| * 65536 / dlen) / 65536)
  function automatic longint push_step(longint unsigned ad, longint unsigned s,
                                       longint unsigned dlen);
    longint unsigned u;
    u = (ad << 16) / dlen;
    return longint'((s * u) >> 16);
  endfunction

  function automatic result_t mk_result(logic [1:0] kind, logic [5:0] other,
                                        logic [31:0] ov, logic [31:0] x,
                                        logic [31:0] y, logic last);
    result_t r;
    r.kind = kind; r.other = other; r.overlap = ov; r.x = x; r.y = y; r.last = last;
    return r;
  endfunction

  // resolve self against the pool and collect the collision reports
  task automatic resolve_pool(int unsigned s, int unsigned start, ref result_t res[$]);
    longint          dx, dy;
    longint unsigned ax, ay, sx, sy, rr, rr2, dlen, ov, r1, r2, s1, s2, mt;
    int unsigned     stop;
    stop = (active_n > POOL) ? POOL : active_n;
    for (int unsigned i = start; i < stop; i++) begin
      if (i == s) continue;
      dx = pool_x[i] - pool_x[s];
      dy = pool_y[i] - pool_y[s];
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sx = ax * ax;
      sy = ay * ay;
      rr = pool_rad[s] + pool_rad[i];
      rr2 = rr * rr;
      if (sx > rr2 || sy > rr2 - sx) continue;
      dlen = int_sqrt(sx + sy);
      ov = rr - dlen + 64'h8000;
      if (ov > 64'hFFFF_FFFF) ov = 64'hFFFF_FFFF;
      if (dlen != 0) begin
        r1 = 64'h8000;
        r2 = 64'h8000;
        mt = pool_mass[s] + pool_mass[i];
        if (mass_split && mt != 0) begin
          r1 = (pool_mass[i] << 16) / mt;
          r2 = (pool_mass[s] << 16) / mt;
        end
        s1 = (ov * r1) >> 16;
        s2 = (ov * r2) >> 16;
        pool_x[s] = clamp32(pool_x[s] + ((dx < 0) ? push_step(ax, s1, dlen)
                                                  : -push_step(ax, s1, dlen)));
        pool_y[s] = clamp32(pool_y[s] + ((dy < 0) ? push_step(ay, s1, dlen)
                                                  : -push_step(ay, s1, dlen)));
        pool_x[i] = clamp32(pool_x[i] + ((dx < 0) ? -push_step(ax, s2, dlen)
                                                  : push_step(ax, s2, dlen)));
        pool_y[i] = clamp32(pool_y[i] + ((dy < 0) ? -push_step(ay, s2, dlen)
                                                  : push_step(ay, s2, dlen)));
      end
      res.push_back(mk_result(KIND_REPORT, i[5:0], ov[31:0], '0, '0, 1'b0));
    end
  endtask

  // update the shadow pool for one accepted request and queue its results
  task automatic predict_request(req_t r);
    result_t res[$];
    int unsigned s;
    s = {26'd0, r.self_idx};
    case (r.op)
      OP_WRITE: begin
        pool_x[s] = longint'($signed(r.px));
        pool_y[s] = longint'($signed(r.py));
        pool_rad[s] = {33'd0, r.rad};
        pool_mass[s] = {33'd0, r.mass};
        res.push_back(mk_result(KIND_ACK, '0, '0, '0, '0, 1'b1));
      end
      OP_READ: begin
        res.push_back(mk_result(KIND_READ, '0, '0, pool_x[s][31:0], pool_y[s][31:0], 1'b1));
      end
      OP_RESOLVE: begin
        resolve_pool(s, {26'd0, r.start_idx}, res);
        res.push_back(mk_result(KIND_DONE, '0, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
    if (r.lit) begin
      res.delete();
      case (r.op)
        OP_WRITE:   res.push_back(mk_result(KIND_ACK, '0, '0, '0, '0, 1'b1));
        OP_READ:    res.push_back(mk_result(KIND_READ, '0, '0, r.lx, r.ly, 1'b1));
        OP_RESOLVE: res.push_back(mk_result(KIND_DONE, '0, '0, '0, '0, 1'b1));
        default: ;
      endcase
    end
    foreach (res[k]) expected_q.push_back(res[k]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    fails++;
  endtask

  // check every result taken from the block
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result kind", {30'd0, out_kind_o}, '0);
      end else begin
        e = expected_q.pop_front();
        if (out_kind_o == KIND_REPORT) n_reports++;
        if (out_kind_o !== e.kind) report_mismatch("kind", out_kind_o, e.kind);
        if (out_other_index_o !== e.other)
          report_mismatch("other_index", out_other_index_o, e.other);
        if (out_overlap_o !== e.overlap) report_mismatch("overlap", out_overlap_o, e.overlap);
        if (out_x_o !== e.x) report_mismatch("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report_mismatch("out_y", out_y_o, e.y);
        if (out_last_o !== e.last) report_mismatch("last", out_last_o, e.last);
      end
    end
  end

  // request builders
  function automatic req_t mk_req(logic [1:0] op, logic [5:0] s, logic [5:0] st,
                                  logic [31:0] x, logic [31:0] y, logic [30:0] rad,
                                  logic [30:0] m, bit lit, logic [31:0] lx,
                                  logic [31:0] ly);
    req_t r;
    r = '{default: '0};
    r.op = op; r.self_idx = s; r.start_idx = st; r.px = x; r.py = y;
    r.rad = rad; r.mass = m; r.lit = lit; r.lx = lx; r.ly = ly;
    return r;
  endfunction

  function automatic req_t mk_cfg(logic idx, logic [6:0] val);
    req_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.cfg_idx = idx; r.cfg_val = val;
    return r;
  endfunction

  // write with content clustered so that resolves see many contacts
  function automatic req_t rand_write(logic [5:0] idx);
    logic [31:0] x, y;
    logic [30:0] rad, m;
    if ($urandom_range(0, 99) < 85) begin
      x = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      y = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      rad = 31'($urandom_range(32'h0000_8000, 32'h0002_0000));
      m = 31'($urandom_range(1, 32'h0004_0000));
    end else begin
      x = $urandom();
      y = $urandom();
      rad = 31'($urandom());
      m = 31'($urandom_range(1, 32'h7FFF_FFFF));
    end
    return mk_req(OP_WRITE, idx, '0, x, y, rad, m, 1'b0, '0, '0);
  endfunction

  function automatic req_t rand_request();
    int unsigned pick;
    logic [5:0] st;
    pick = $urandom_range(0, 99);
    st = ($urandom_range(0, 99) < 60) ? 6'd0 : 6'($urandom_range(0, 63));
    if (pick < 45)
      return mk_req(OP_RESOLVE, 6'($urandom_range(0, 63)), st, $urandom(), $urandom(),
                    31'($urandom()), 31'($urandom()), 1'b0, '0, '0);
    if (pick < 70) return rand_write(6'($urandom_range(0, 63)));
    if (pick < 90)
      return mk_req(OP_READ, 6'($urandom_range(0, 63)), 6'($urandom()), $urandom(),
                    $urandom(), 31'($urandom()), 31'($urandom()), 1'b0, '0, '0);
    return mk_req(OP_NONE, 6'($urandom()), 6'($urandom()), $urandom(), $urandom(),
                  31'($urandom()), 31'($urandom()), 1'b0, '0, '0);
  endfunction

  // hold off until every result is back and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_USE_MASS) mass_split = val[0];
    else active_n = {25'd0, val};
  endtask

  // send one request, hold it until taken, then maybe open a gap
  int unsigned burst_left;
  task automatic send(req_t r);
    int unsigned gap;
    if (r.is_cfg) begin
      write_reg(r.cfg_idx, r.cfg_val);
      return;
    end
    in_valid_i <= 1'b1;
    in_op_i <= r.op;
    in_self_index_i <= r.self_idx;
    in_start_index_i <= r.start_idx;
    in_pos_x_i <= r.px;
    in_pos_y_i <= r.py;
    in_radius_i <= r.rad;
    in_mass_i <= r.mass;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(r);
    n_requests++;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(0, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  req_t directed[$];
  logic [6:0] phase_active [6] = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd33, 7'd64};
  logic       phase_mass   [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    fails = 0;
    n_requests = 0;
    n_reports = 0;
    burst_left = 0;
    mass_split = 1'b0;
    active_n = 0;
    foreach (pool_x[i]) begin
      pool_x[i] = 0; pool_y[i] = 0; pool_rad[i] = 0; pool_mass[i] = 0;
    end

    // extremes, coincident pair, start past count, ignored op, clamped moves
    directed.push_back(mk_req(OP_WRITE, 6'd0, 6'd0, 32'h0, 32'h0, 31'h0001_0000,
                              31'h0001_0000, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_WRITE, 6'd1, 6'd0, 32'h0001_8000, 32'h0, 31'h0001_0000,
                              31'h0003_0000, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_WRITE, 6'd2, 6'd0, 32'h0, 32'h0, 31'h0000_8000,
                              31'h0000_0001, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_WRITE, 6'd3, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_WRITE, 6'd63, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF,
                              31'h0, 31'h1, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_READ, 6'd3, 6'd0, '0, '0, '0, '0, 1'b1,
                              32'h7FFF_FFFF, 32'h8000_0000));
    directed.push_back(mk_req(OP_READ, 6'd63, 6'd0, '0, '0, '0, '0, 1'b1,
                              32'h8000_0000, 32'h7FFF_FFFF));
    directed.push_back(mk_req(OP_RESOLVE, 6'd0, 6'd0, '0, '0, '0, '0, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_NONE, 6'd5, 6'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, '0, '0));
    directed.push_back(mk_cfg(CFG_ACTIVE, 7'd4));
    directed.push_back(mk_req(OP_RESOLVE, 6'd0, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_READ, 6'd0, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_READ, 6'd1, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_RESOLVE, 6'd1, 6'd3, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_RESOLVE, 6'd0, 6'd63, '0, '0, '0, '0, 1'b1, '0, '0));
    directed.push_back(mk_cfg(CFG_USE_MASS, 7'd1));
    directed.push_back(mk_req(OP_RESOLVE, 6'd1, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_WRITE, 6'd4, 6'd0, 32'h7FFF_FFFE, 32'h0, 31'h7FFF_FFFF,
                              31'h1, 1'b1, '0, '0));
    directed.push_back(mk_req(OP_WRITE, 6'd5, 6'd0, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF,
                              31'h7FFF_FFFF, 1'b1, '0, '0));
    directed.push_back(mk_cfg(CFG_ACTIVE, 7'd6));
    directed.push_back(mk_req(OP_RESOLVE, 6'd4, 6'd4, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_READ, 6'd4, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_READ, 6'd5, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));
    directed.push_back(mk_req(OP_RESOLVE, 6'd2, 6'd0, '0, '0, '0, '0, 1'b0, '0, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed[i]) send(directed[i]);

    // fill the pool so that any index is safe to read or resolve
    for (int i = 0; i < POOL; i++) send(rand_write(6'(i)));

    // random phases; each register change waits for the block to drain
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_USE_MASS, {6'd0, phase_mass[p]});
      write_reg(CFG_ACTIVE, phase_active[p]);
      for (int k = 0; k < 3; k++) send(rand_request());
    end

    drain();
    $display("covered %0d requests, %0d collision reports, 6 register settings",
             n_requests, n_reports);
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", fails);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
